FILE: src/hvt_pkg.sv
// ============================================================================
// hvt_pkg
// Types, widths and helpers shared by the vertex transform core and its
// channel interfaces.
// ============================================================================
`default_nettype none

package hvt_pkg;

    localparam int FRAC_BITS = 16;

    localparam int DW   = 32;               // vector component width
    localparam int PW   = 2 * DW;           // one matrix product
    localparam int AW   = PW + 2;           // exact row sum of four products
    localparam int SW   = AW - FRAC_BITS;   // row result after the floor shift
    localparam int MW   = SW;               // magnitude of a row result
    localparam int LW   = $clog2(MW);       // leading-one position
    localparam int NW   = DW - 1;           // normalized direction component
    localparam int QW   = DW - 1;           // quotient bits
    localparam int SQW  = 2 * DW;           // sum of squares
    localparam int RTW  = SQW / 2;          // square root steps
    localparam int NREG = 8;                // configuration registers
    localparam int IDXW = 4;                // configuration index width
    localparam int CDW  = 2 * DW;           // configuration data width

    typedef enum logic {
        MODE_POINT = 1'b0,
        MODE_DIR   = 1'b1
    } mode_t;

    typedef logic signed [DW-1:0] word_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [SW-1:0] row_t;
    typedef logic [MW-1:0]        mag_t;
    typedef logic [SQW-1:0]       sq_t;

    localparam word_t ONE     = word_t'(1 << FRAC_BITS);
    localparam word_t SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam word_t SAT_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic       dir;
        logic       degen;
        logic [2:0] neg;
        logic [2:0] nz;
    } ctl_t;

    typedef struct packed {
        ctl_t       ctl;
        mag_t [2:0] num;
        mag_t       den;
    } item_t;

    typedef struct packed {
        item_t it;
        sq_t   rem;
        sq_t   root;
    } root_t;

    typedef struct packed {
        mag_t          r;
        logic [QW-1:0] lo;
        logic [QW-1:0] q;
        logic          sat;
    } lane_t;

    typedef struct packed {
        ctl_t        ctl;
        mag_t        den;
        lane_t [2:0] lane;
    } div_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
        logic  degenerate;
    } res_t;

    function automatic prod_t mul(input word_t a, input word_t b);
        return PW'(a) * PW'(b);
    endfunction

    function automatic mag_t mag_of(input row_t v);
        logic [SW-1:0] u;
        u = v;
        return v[SW-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic logic [LW-1:0] lead_one(input mag_t v);
        logic [LW-1:0] p;
        p = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (v[i])
            begin
                p = LW'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: src/hvt_if.sv
// ============================================================================
// hvt channel interfaces
// Vertex input, result output and matrix write channels, valid/ready.
// ============================================================================
`default_nettype none

interface hvt_vertex_if
    import hvt_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  mode;
    word_t in_x;
    word_t in_y;
    word_t in_z;

    modport source (output valid, mode, in_x, in_y, in_z, input ready);
    modport sink   (input valid, mode, in_x, in_y, in_z, output ready);
endinterface

interface hvt_result_if
    import hvt_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t out_x;
    word_t out_y;
    word_t out_z;
    logic  degenerate;

    modport source (output valid, out_x, out_y, out_z, degenerate, input ready);
    modport sink   (input valid, out_x, out_y, out_z, degenerate, output ready);
endinterface

interface hvt_cfg_if
    import hvt_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [IDXW-1:0] index;
    logic [CDW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/homogeneous_vertex_transform_core.sv
// ============================================================================
// homogeneous_vertex_transform_core
// 4x4 homogeneous transform of Q16.16 vectors: points are divided by w,
// directions are scaled to unit length.
//
//   channel  role    handshake      payload
//   vertex   sink    valid/ready    mode, in_x, in_y, in_z
//   result   source  valid/ready    out_x, out_y, out_z, degenerate
//   cfg      sink    valid/ready    index, data (ready always high)
//
// One item per cycle while the skid entry is free, through the 32-step square
// root pipeline followed by the 31-step divider pipeline.
// rst_n clears valid bits and loads the identity matrix.
// A two-entry output register + skid stage holds results; the pipeline
// freezes only while the skid entry is occupied.
// ============================================================================
`default_nettype none

module homogeneous_vertex_transform_core
    import hvt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    hvt_vertex_if.sink   vertex,
    hvt_result_if.source result,
    hvt_cfg_if.sink      cfg
);

    localparam int ST_SH  = 4;
    localparam int ST_RT  = 6;
    localparam int ST_DIV = ST_RT + RTW + 1;
    localparam int NST    = ST_DIV + QW + 1;

    word_t          mat_reg [4][4];
    logic [NST-1:0] valid_reg;
    logic           en;

    logic           dir1_reg;
    prod_t          prod_reg [4][3];
    logic           dir2_reg;
    row_t           row_reg [4];
    row_t           row_next [4];
    logic signed [AW-1:0] acc [4];
    logic signed [AW-1:0] c3 [4];

    item_t          mag_reg, mag_next;
    item_t          lz_item_reg;
    logic [LW-1:0]  lz_reg;
    item_t          sh_reg, sh_next;
    mag_t           norm_or;
    item_t          sq_item_reg;
    logic [2*NW-1:0] sq_reg [3];

    root_t          rt_reg [RTW+1];
    div_t           div_reg [QW+1];
    div_t           d0_next;
    logic [MW+FRAC_BITS-1:0]    wide [3];
    logic [MW+FRAC_BITS-QW-1:0] r0 [3];

    res_t           fin;
    res_t           out_reg, out_next;
    res_t           skid_reg, skid_next;
    logic           out_valid_reg, out_valid_next;
    logic           skid_full_reg, skid_full_next;
    logic           out_take;
    logic           skid_load;

    // ------------------------------------------------------------------
    // matrix registers
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    mat_reg[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end
        else if (cfg.valid && cfg.ready && cfg.index < IDXW'(NREG))
        begin
            mat_reg[cfg.index[2:1]][{cfg.index[0], 1'b0}] <= cfg.data[DW-1:0];
            mat_reg[cfg.index[2:1]][{cfg.index[0], 1'b1}] <= cfg.data[CDW-1:DW];
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    assign en           = !skid_full_reg;
    assign vertex.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NST-2:0], vertex.valid};
        end
    end

    // ------------------------------------------------------------------
    // products, row sums, magnitudes
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dir1_reg <= (vertex.mode == MODE_DIR);
            for (int r = 0; r < 4; r++)
            begin
                prod_reg[r][0] <= mul(mat_reg[r][0], vertex.in_x);
                prod_reg[r][1] <= mul(mat_reg[r][1], vertex.in_y);
                prod_reg[r][2] <= mul(mat_reg[r][2], vertex.in_z);
            end
        end
    end

    // column 3 sees w = 1.0 for points, 0 for directions
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            c3[r]       = dir1_reg ? '0 : (AW'(mat_reg[r][3]) <<< FRAC_BITS);
            acc[r]      = AW'(prod_reg[r][0]) + AW'(prod_reg[r][1])
                        + AW'(prod_reg[r][2]) + c3[r];
            row_next[r] = acc[r][AW-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dir2_reg <= dir1_reg;
            row_reg  <= row_next;
        end
    end

    always_comb
    begin
        mag_next.ctl.dir = dir2_reg;
        for (int i = 0; i < 3; i++)
        begin
            mag_next.num[i]    = mag_of(row_reg[i]);
            mag_next.ctl.nz[i] = |row_reg[i];
            mag_next.ctl.neg[i] = row_reg[i][SW-1] ^ (row_reg[3][SW-1] & !dir2_reg);
        end
        mag_next.den       = mag_of(row_reg[3]);
        mag_next.ctl.degen = dir2_reg ? ~|mag_next.ctl.nz : ~|row_reg[3];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg     <= mag_next;
            lz_item_reg <= mag_reg;
            lz_reg      <= lead_one(mag_reg.num[0] | mag_reg.num[1] | mag_reg.num[2]);
        end
    end

    // ------------------------------------------------------------------
    // direction: common shift so the largest magnitude is in [2^30, 2^31)
    // ------------------------------------------------------------------
    always_comb
    begin
        sh_next = lz_item_reg;
        if (lz_item_reg.ctl.dir)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (lz_reg >= LW'(NW-1))
                begin
                    sh_next.num[i] = lz_item_reg.num[i] >> (lz_reg - LW'(NW-1));
                end
                else
                begin
                    sh_next.num[i] = lz_item_reg.num[i] << (LW'(NW-1) - lz_reg);
                end
                sh_next.num[i] = MW'(sh_next.num[i][NW-1:0]);
            end
        end
    end

    assign norm_or = sh_reg.num[0] | sh_reg.num[1] | sh_reg.num[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_reg      <= sh_next;
            sq_item_reg <= sh_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= {{NW{1'b0}}, sh_reg.num[i][NW-1:0]}
                           * {{NW{1'b0}}, sh_reg.num[i][NW-1:0]};
            end
            rt_reg[0].it   <= sq_item_reg;
            rt_reg[0].rem  <= SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]);
            rt_reg[0].root <= '0;
        end
    end

    // ------------------------------------------------------------------
    // integer square root, one result bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < RTW; k++)
    begin : g_root
        localparam sq_t BIT = sq_t'(1) << (SQW - 2 - 2 * k);
        sq_t   rb;
        root_t step;

        always_comb
        begin
            rb   = rt_reg[k].root + BIT;
            step = rt_reg[k];
            if (rt_reg[k].rem >= rb)
            begin
                step.rem  = rt_reg[k].rem - rb;
                step.root = (rt_reg[k].root >> 1) + BIT;
            end
            else
            begin
                step.root = rt_reg[k].root >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_reg[k+1] <= step;
            end
        end
    end

    // ------------------------------------------------------------------
    // divider entry: pick divisor, split dividend, saturation check
    // ------------------------------------------------------------------
    always_comb
    begin
        d0_next.ctl = rt_reg[RTW].it.ctl;
        d0_next.den = rt_reg[RTW].it.ctl.dir ? MW'(rt_reg[RTW].root) : rt_reg[RTW].it.den;
        for (int i = 0; i < 3; i++)
        begin
            wide[i] = {rt_reg[RTW].it.num[i], {FRAC_BITS{1'b0}}};
            r0[i]   = wide[i][MW+FRAC_BITS-1:QW];
            d0_next.lane[i].r   = MW'(r0[i]);
            d0_next.lane[i].lo  = wide[i][QW-1:0];
            d0_next.lane[i].q   = '0;
            d0_next.lane[i].sat = MW'(r0[i]) >= d0_next.den;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0] <= d0_next;
        end
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage, three lanes
    // ------------------------------------------------------------------
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        div_t        step;
        logic [MW:0] rs [3];
        logic [MW:0] diff [3];
        logic        ge [3];

        always_comb
        begin
            step = div_reg[j];
            for (int i = 0; i < 3; i++)
            begin
                rs[i]   = {div_reg[j].lane[i].r, div_reg[j].lane[i].lo[QW-1]};
                diff[i] = rs[i] - {1'b0, div_reg[j].den};
                ge[i]   = rs[i] >= {1'b0, div_reg[j].den};
                step.lane[i].r  = ge[i] ? diff[i][MW-1:0] : rs[i][MW-1:0];
                step.lane[i].lo = div_reg[j].lane[i].lo << 1;
                step.lane[i].q  = {div_reg[j].lane[i].q[QW-2:0], ge[i]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[j+1] <= step;
            end
        end
    end

    // ------------------------------------------------------------------
    // result formatting
    // ------------------------------------------------------------------
    function automatic word_t fmt(input ctl_t c, input int i, input lane_t ln);
        word_t qv;
        qv = {1'b0, ln.q};
        if (c.degen)
        begin
            return c.nz[i] ? (c.neg[i] ? SAT_MIN : SAT_MAX) : '0;
        end
        else if (ln.sat)
        begin
            return c.neg[i] ? SAT_MIN : SAT_MAX;
        end
        return c.neg[i] ? -qv : qv;
    endfunction

    always_comb
    begin
        fin.x          = fmt(div_reg[QW].ctl, 0, div_reg[QW].lane[0]);
        fin.y          = fmt(div_reg[QW].ctl, 1, div_reg[QW].lane[1]);
        fin.z          = fmt(div_reg[QW].ctl, 2, div_reg[QW].lane[2]);
        fin.degenerate = div_reg[QW].ctl.degen;
    end

    // ------------------------------------------------------------------
    // output register and skid entry
    // ------------------------------------------------------------------
    always_comb
    begin
        out_take       = out_valid_reg & result.ready;
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        out_next       = out_reg;
        skid_load      = 1'b0;
        if (skid_full_reg)
        begin
            if (out_take)
            begin
                out_next       = skid_reg;
                skid_full_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_next = valid_reg[NST-1];
            out_next       = fin;
        end
        else if (valid_reg[NST-1])
        begin
            skid_full_next = 1'b1;
            skid_load      = 1'b1;
        end
        skid_next = skid_load ? fin : skid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.out_x      = out_reg.x;
    assign result.out_y      = out_reg.y;
    assign result.out_z      = out_reg.z;
    assign result.degenerate = out_reg.degenerate;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid entry occupied with empty output register");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(valid_reg[NST-1] && out_valid_reg && !result.ready))
        else $error("skid entry filled without a blocked result");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("pipeline moved while frozen");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_SH] && sh_reg.ctl.dir && !sh_reg.ctl.degen
        |-> norm_or[NW-1] && ((norm_or >> NW) == '0))
        else $error("direction not normalized into range");

    a_dir_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_DIV] && div_reg[0].ctl.dir && !div_reg[0].ctl.degen
        |-> !div_reg[0].lane[0].sat && !div_reg[0].lane[1].sat && !div_reg[0].lane[2].sat)
        else $error("unit direction quotient overflow");
`endif

endmodule

`default_nettype wire
